FILE: hw/rtl/bmd_pkg.sv
// Shared types and constants of the backend message deframer.
`default_nettype none

package bmd_pkg;

    // Message tags
    localparam logic [7:0] TAG_AUTH  = 8'h52;  // 'R'
    localparam logic [7:0] TAG_ERROR = 8'h45;  // 'E'
    localparam logic [7:0] TAG_READY = 8'h5A;  // 'Z'

    // Authentication subcodes
    localparam logic [31:0] SUB_OK    = 32'd0;
    localparam logic [31:0] SUB_CLEAR = 32'd3;
    localparam logic [31:0] SUB_MD5   = 32'd5;
    localparam logic [31:0] SUB_SASL  = 32'd10;
    localparam logic [31:0] SUB_CONT  = 32'd11;
    localparam logic [31:0] SUB_FINAL = 32'd12;

    // Message classes
    localparam logic [3:0] CL_OK     = 4'd0;
    localparam logic [3:0] CL_CLEAR  = 4'd1;
    localparam logic [3:0] CL_MD5    = 4'd2;
    localparam logic [3:0] CL_SASL   = 4'd3;
    localparam logic [3:0] CL_CONT   = 4'd4;
    localparam logic [3:0] CL_FINAL  = 4'd5;
    localparam logic [3:0] CL_UNSUP  = 4'd6;
    localparam logic [3:0] CL_BADMD5 = 4'd7;
    localparam logic [3:0] CL_ERR    = 4'd8;
    localparam logic [3:0] CL_READY  = 4'd9;
    localparam logic [3:0] CL_SKIP   = 4'd10;
    localparam logic [3:0] CL_BADLEN = 4'd11;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] code;
        logic        long8;
    } cls_req_t;

    typedef struct packed {
        logic [3:0] msg_class;
        logic       halt;
    } cls_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bmd_classify.sv
// Message classifier: maps tag, subcode and body size to a class and halt flag.
`default_nettype none

module bmd_classify
    import bmd_pkg::*;
(
    input  cls_req_t req,
    output cls_res_t res
);

    always_comb
    begin
        res.msg_class = CL_SKIP;
        res.halt      = 1'b0;
        unique case (req.tag)
            TAG_AUTH:
            begin
                unique case (req.code)
                    SUB_OK:    res.msg_class = CL_OK;
                    SUB_CLEAR: res.msg_class = CL_CLEAR;
                    SUB_MD5:
                    begin
                        if (req.long8)
                        begin
                            res.msg_class = CL_MD5;
                        end
                        else
                        begin
                            res.msg_class = CL_BADMD5;
                            res.halt      = 1'b1;
                        end
                    end
                    SUB_SASL:  res.msg_class = CL_SASL;
                    SUB_CONT:  res.msg_class = CL_CONT;
                    SUB_FINAL: res.msg_class = CL_FINAL;
                    default:
                    begin
                        res.msg_class = CL_UNSUP;
                        res.halt      = 1'b1;
                    end
                endcase
            end
            TAG_ERROR:
            begin
                res.msg_class = CL_ERR;
                res.halt      = 1'b1;
            end
            TAG_READY:
            begin
                res.msg_class = CL_READY;
                res.halt      = 1'b1;
            end
            default:
            begin
                res.msg_class = CL_SKIP;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/backend_message_deframer_core.sv
// Top level of the backend message deframer: byte framing, body pass-through, classing.
//
//  channel | dir | handshake         | content
//  s_*     | in  | s_tvalid/s_tready | one received byte per item
//  m_*     | out | m_tvalid/m_tready | body byte and/or message class, tlast on message end
//
// One byte is taken per cycle while s_tready is high; its result lands in the output register the next cycle.
// The output register frees s_tready whenever it is empty or being drained.
// Reset returns the framer to expecting a tag byte and empties the output register.
// After a halting message every byte is accepted and dropped until reset.
`default_nettype none

module backend_message_deframer_core
    import bmd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] body_data, [15:8] msg_tag, [46:16] body_length, [78:47] auth_code,
    // [110:79] md5_salt, [111] halted
    output logic [111:0]      m_tdata,
    // [0] body_valid, [4:1] msg_class
    output logic [4:0]        m_tuser,
    output logic              m_tlast    // last_of_msg
);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t        phase_reg,    phase_next;
    logic [7:0]    tag_reg,      tag_next;
    logic [23:0]   len_reg,      len_next;
    logic [1:0]    len_cnt_reg,  len_cnt_next;
    logic [30:0]   blen_reg,     blen_next;
    logic [30:0]   remain_reg,   remain_next;
    logic [3:0]    idx_reg,      idx_next;
    logic [31:0]   sub_reg,      sub_next;
    logic [31:0]   salt_reg,     salt_next;
    logic          stopped_reg,  stopped_next;
    logic          ovalid_reg,   ovalid_next;
    logic [111:0]  odata_reg,    odata_next;
    logic [4:0]    ouser_reg,    ouser_next;
    logic          olast_reg,    olast_next;

    logic          accept;
    logic [31:0]   full_len;
    logic [30:0]   blen_calc;
    logic          len_bad;
    logic          len_empty;
    logic          blen_ge4;
    logic          blen_ge8;
    cls_req_t      creq;
    cls_res_t      cres;

    assign s_tready = !ovalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

    assign full_len  = {len_reg, s_tdata};
    assign len_bad   = full_len[31] || (full_len[30:2] == 29'd0);
    assign len_empty = (full_len == 32'd4);
    assign blen_calc = full_len[30:0] - 31'd4;
    assign blen_ge4  = (blen_reg[30:2] != 29'd0);
    assign blen_ge8  = (blen_reg[30:3] != 28'd0);

    // Shift subcode and salt on the first eight body bytes
    always_comb
    begin
        sub_next  = sub_reg;
        salt_next = salt_reg;
        if (idx_reg < 4'd4)
        begin
            sub_next = {sub_reg[23:0], s_tdata};
        end
        else if (idx_reg < 4'd8)
        begin
            salt_next = {salt_reg[23:0], s_tdata};
        end
    end

    always_comb
    begin
        creq.tag   = tag_reg;
        creq.code  = (phase_reg == PH_BODY && blen_ge4) ? sub_next : 32'hFFFF_FFFF;
        creq.long8 = (phase_reg == PH_BODY) && blen_ge8;
    end

    bmd_classify u_classify (
        .req (creq),
        .res (cres)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        len_cnt_next = len_cnt_reg;
        blen_next    = blen_reg;
        remain_next  = remain_reg;
        idx_next     = idx_reg;
        stopped_next = stopped_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        olast_next   = olast_reg;

        if (accept && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    len_next     = full_len[23:0];
                    len_cnt_next = len_cnt_reg + 2'd1;
                    if (len_cnt_reg == 2'd3)
                    begin
                        if (len_bad)
                        begin
                            ovalid_next  = 1'b1;
                            odata_next   = {1'b1, 32'd0, 32'hFFFF_FFFF, 31'd0, tag_reg, 8'd0};
                            ouser_next   = {CL_BADLEN, 1'b0};
                            olast_next   = 1'b1;
                            stopped_next = 1'b1;
                            phase_next   = PH_TAG;
                        end
                        else if (len_empty)
                        begin
                            ovalid_next  = 1'b1;
                            odata_next   = {cres.halt, 32'd0, creq.code, 31'd0, tag_reg, 8'd0};
                            ouser_next   = {cres.msg_class, 1'b0};
                            olast_next   = 1'b1;
                            stopped_next = cres.halt;
                            phase_next   = PH_TAG;
                        end
                        else
                        begin
                            blen_next   = blen_calc;
                            remain_next = blen_calc;
                            phase_next  = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    remain_next = remain_reg - 31'd1;
                    if (idx_reg < 4'd8)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    ovalid_next = 1'b1;
                    if (remain_reg == 31'd1)
                    begin
                        odata_next   = {cres.halt, (blen_ge8 ? salt_next : 32'd0), creq.code,
                                        blen_reg, tag_reg, s_tdata};
                        ouser_next   = {cres.msg_class, 1'b1};
                        olast_next   = 1'b1;
                        stopped_next = cres.halt;
                        phase_next   = PH_TAG;
                    end
                    else
                    begin
                        odata_next = {1'b0, 32'd0, 32'd0, blen_reg, tag_reg, s_tdata};
                        ouser_next = {CL_OK, 1'b1};
                        olast_next = 1'b0;
                    end
                end
                default:
                begin
                    // Tag byte: open a new message
                    tag_next     = s_tdata;
                    len_next     = 24'd0;
                    len_cnt_next = 2'd0;
                    remain_next  = 31'd0;
                    idx_next     = 4'd0;
                    phase_next   = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            tag_reg     <= 8'd0;
            len_reg     <= 24'd0;
            len_cnt_reg <= 2'd0;
            blen_reg    <= 31'd0;
            remain_reg  <= 31'd0;
            idx_reg     <= 4'd0;
            sub_reg     <= 32'd0;
            salt_reg    <= 32'd0;
            stopped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            odata_reg   <= 112'd0;
            ouser_reg   <= 5'd0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            len_cnt_reg <= len_cnt_next;
            blen_reg    <= blen_next;
            remain_reg  <= remain_next;
            idx_reg     <= idx_next;
            stopped_reg <= stopped_next;
            ovalid_reg  <= ovalid_next;
            odata_reg   <= odata_next;
            ouser_reg   <= ouser_next;
            olast_reg   <= olast_next;
            if (accept && !stopped_reg)
            begin
                if (phase_reg == PH_BODY)
                begin
                    sub_reg  <= sub_next;
                    salt_reg <= salt_next;
                end
                else if (phase_reg != PH_LEN)
                begin
                    sub_reg  <= 32'd0;
                    salt_reg <= 32'd0;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bmd_checker.sv
// Port-level checks of the backend message deframer, bound to the top level.
`default_nettype none

module bmd_checker
    import bmd_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic [4:0]   m_tuser,
    input wire logic         m_tlast
);

    // Hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled output item changed");

    // Nothing follows a halting item
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[111]) |=> !m_tvalid)
        else $error("output after halt");

    a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[111]) |-> m_tlast)
        else $error("halt on non-final item");

    a_nobody_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("item without body byte is not final");

    a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[4:1] == CL_OK && m_tdata[110:47] == 64'd0))
        else $error("class fields set on non-final item");

endmodule

bind backend_message_deframer_core bmd_checker u_bmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
